// ----- hw/rtl/ivwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivwm_pkg
// shared constants and types of the inverse-variance window merge block
// ----------------------------------------------------------------------------
package ivwm_pkg;

	// default ring depth, largest window length
	localparam int unsigned MAX_WINDOW_DEF = 16;

	// window length after reset
	localparam logic [4:0] WINDOW_LEN_RST = 5'd5;

	// weighted power is w*p / 2^WP_SHIFT
	localparam int unsigned WP_SHIFT = 22;

	// saturated weight, Q16.32
	localparam logic [47:0] WEIGHT_MAX = 48'hFFFF_FFFF_FFFF;

	// scaled sigma squared at or below this saturates the weight
	localparam logic [63:0] TINY_SQ = 64'd65536;

	// dividend width of the back-end divider: 64-bit magnitude plus shift
	localparam int unsigned BACK_NUM_W = 64 + WP_SHIFT;

	// entries of the queue between front and back end
	localparam int unsigned QUEUE_DEPTH = 2;

	// one full window handed from front to back end
	typedef struct packed {
		logic [63:0] weight_sum;
		logic [63:0] wpower_sum;
		logic [31:0] freq;
		logic        sigma_zero;
	} win_sum_t;

endpackage

// ----- hw/rtl/ivwm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivwm_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ivwm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/ivwm_divu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivwm_divu
// restoring unsigned divider, one quotient bit per cycle, sticky overflow
// ----------------------------------------------------------------------------
module ivwm_divu #(
	parameter int unsigned NUM_W = 65,
	parameter int unsigned QUO_W = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [63:0]      den,
	output logic             done,
	output logic [QUO_W-1:0] quot,
	output logic             ovf
);

	localparam int unsigned CW = $clog2(NUM_W + 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(NUM_W - 1);

	logic             run_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [63:0]      den_q;
	logic [63:0]      rem_q;
	logic [QUO_W-1:0] quot_q;
	logic             ovf_q;

	logic [64:0] rem_sh;
	logic        ge;
	logic [64:0] rem_sub;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (run_q) begin
			num_q  <= num_q << 1;
			rem_q  <= ge ? rem_sub[63:0] : rem_sh[63:0];
			quot_q <= {quot_q[QUO_W-2:0], ge};
			ovf_q  <= ovf_q | quot_q[QUO_W-1];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign ovf  = ovf_q;

endmodule

// ----- hw/rtl/ivwm_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivwm_sqrt
// 64-bit integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module ivwm_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [31:0] root
);

	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] x_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (run_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// ----- hw/rtl/ivwm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivwm_front
// accepts bins, scales them, forms weight and weighted power, keeps the window
// ----------------------------------------------------------------------------
module ivwm_front #(
	parameter int unsigned MAX_WINDOW = ivwm_pkg::MAX_WINDOW_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [4:0]              cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [31:0]      power_in,
	input  logic [31:0]             sigma_in,
	input  logic [31:0]             freq_code,
	input  logic                    restart,
	output logic                    q_valid,
	input  logic                    q_ready,
	output ivwm_pkg::win_sum_t      q_data
);

	localparam int unsigned IW = $clog2(MAX_WINDOW);
	localparam int unsigned KW = $clog2(MAX_WINDOW + 1);
	localparam logic [IW:0] DEPTH_X = (IW+1)'(MAX_WINDOW);

	typedef enum logic [7:0] {
		F_IDLE = 8'b0000_0001,
		F_SQ   = 8'b0000_0010,
		F_DIV  = 8'b0000_0100,
		F_MUL1 = 8'b0000_1000,
		F_MUL2 = 8'b0001_0000,
		F_UPD  = 8'b0010_0000,
		F_FRQ  = 8'b0100_0000,
		F_PUSH = 8'b1000_0000
	} front_state_t;

	front_state_t state_q;

	logic [4:0]            window_len_q;
	logic [KW-1:0]         fill_q;
	logic [IW-1:0]         wptr_q;
	logic [63:0]           wsum_q;
	logic [63:0]           wpsum_q;
	logic [MAX_WINDOW-1:0] zbits_q;

	logic [KW-1:0]  k_q;
	logic           neg_q;
	logic [31:0]    mag_q;
	logic [31:0]    s_q;
	logic [31:0]    freq_q;
	logic           zero_q;
	logic [47:0]    w_q;
	logic [57:0]    hi_q;
	logic [63:0]    wp_q;
	logic [IW-1:0]  old_out_q;
	logic           zeros_q;

	// clamped window length and scaling of the incoming bin
	logic [KW-1:0]      k_eff;
	logic signed [47:0] p_prod;
	logic signed [31:0] p_sat;
	logic [39:0]        s_prod;
	logic [31:0]        s_sat;

	always_comb begin
		if (window_len_q == 5'd0) begin
			k_eff = KW'(1);
		end else if (32'(window_len_q) > MAX_WINDOW) begin
			k_eff = KW'(MAX_WINDOW);
		end else begin
			k_eff = KW'(window_len_q);
		end
	end

	assign p_prod = 48'(power_in) * $signed(48'(k_eff));
	assign s_prod = 40'(sigma_in) * 40'(k_eff);

	always_comb begin
		if (p_prod > 48'sd2147483647) begin
			p_sat = 32'sh7FFF_FFFF;
		end else if (p_prod < -48'sd2147483648) begin
			p_sat = 32'sh8000_0000;
		end else begin
			p_sat = p_prod[31:0];
		end
		s_sat = (s_prod[39:32] != 8'd0) ? 32'hFFFF_FFFF : s_prod[31:0];
	end

	// sigma squared and the reciprocal divider
	logic [63:0] sq;
	logic        sq_tiny;
	logic        div_done;
	logic [47:0] div_quot;
	logic        div_ovf;

	assign sq      = 64'(s_q) * 64'(s_q);
	assign sq_tiny = sq <= ivwm_pkg::TINY_SQ;

	ivwm_divu #(
		.NUM_W(65),
		.QUO_W(48)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == F_SQ && !sq_tiny),
		.num   ({1'b1, 64'd0}),
		.den   (sq),
		.done  (div_done),
		.quot  (div_quot),
		.ovf   (div_ovf)
	);

	// weighted power, low partial product
	logic [53:0] lo_prod;
	logic [63:0] wp_mag;

	assign lo_prod = 54'(w_q[ivwm_pkg::WP_SHIFT-1:0]) * 54'(mag_q);
	assign wp_mag  = 64'(hi_q) + 64'(lo_prod[53:ivwm_pkg::WP_SHIFT]);

	// ring addresses
	logic [IW:0]   old_sub_x;
	logic [IW-1:0] old_sub;
	logic [IW-1:0] wptr_nx;
	logic [IW:0]   old_out_x;
	logic [IW-1:0] old_out;
	logic          full_before;
	logic          full_after;

	assign old_sub_x = (IW+1)'(wptr_q) + DEPTH_X - (IW+1)'(k_q);
	assign old_sub   = (old_sub_x >= DEPTH_X) ? IW'(old_sub_x - DEPTH_X) : IW'(old_sub_x);
	assign wptr_nx   = (32'(wptr_q) == MAX_WINDOW - 1) ? '0 : wptr_q + 1'b1;
	assign old_out_x = (IW+1)'(wptr_nx) + DEPTH_X - (IW+1)'(k_q);
	assign old_out   = (old_out_x >= DEPTH_X) ? IW'(old_out_x - DEPTH_X) : IW'(old_out_x);

	assign full_before = fill_q >= k_q;
	assign full_after  = full_before || (fill_q + 1'b1 == k_q);

	logic [47:0] w_rd;
	logic [63:0] wp_rd;
	logic [31:0] freq_rd;
	logic        ring_we;

	assign ring_we = state_q == F_UPD;

	ivwm_ram #(.WIDTH(48), .DEPTH(MAX_WINDOW)) u_wram (
		.clk(clk), .we(ring_we), .waddr(wptr_q), .wdata(w_q),
		.raddr(old_sub), .rdata(w_rd)
	);

	ivwm_ram #(.WIDTH(64), .DEPTH(MAX_WINDOW)) u_wpram (
		.clk(clk), .we(ring_we), .waddr(wptr_q), .wdata(wp_q),
		.raddr(old_sub), .rdata(wp_rd)
	);

	ivwm_ram #(.WIDTH(32), .DEPTH(MAX_WINDOW)) u_fram (
		.clk(clk), .we(ring_we), .waddr(wptr_q), .wdata(freq_q),
		.raddr(old_out_q), .rdata(freq_rd)
	);

	// any zero sigma among the last k entries
	logic zeros_any;

	always_comb begin
		logic [IW:0] age;
		zeros_any = 1'b0;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			age = (IW+1)'(wptr_q) + DEPTH_X - 1'b1 - (IW+1)'(j);
			if (age >= DEPTH_X) begin
				age = age - DEPTH_X;
			end
			if ((age < (IW+1)'(k_q)) && zbits_q[j]) begin
				zeros_any = 1'b1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			window_len_q <= ivwm_pkg::WINDOW_LEN_RST;
			fill_q       <= '0;
			wptr_q       <= '0;
			wsum_q       <= '0;
			wpsum_q      <= '0;
			zbits_q      <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (cfg_we) begin
						window_len_q <= cfg_wdata;
						fill_q       <= '0;
						wptr_q       <= '0;
						wsum_q       <= '0;
						wpsum_q      <= '0;
						zbits_q      <= '0;
					end else if (in_valid) begin
						if (restart) begin
							fill_q  <= '0;
							wptr_q  <= '0;
							wsum_q  <= '0;
							wpsum_q <= '0;
							zbits_q <= '0;
						end
						state_q <= F_SQ;
					end
				end
				F_SQ: begin
					state_q <= sq_tiny ? F_MUL1 : F_DIV;
				end
				F_DIV: begin
					if (div_done) begin
						state_q <= F_MUL1;
					end
				end
				F_MUL1: begin
					state_q <= F_MUL2;
				end
				F_MUL2: begin
					state_q <= F_UPD;
				end
				F_UPD: begin
					wsum_q  <= wsum_q - (full_before ? 64'(w_rd) : 64'd0) + 64'(w_q);
					wpsum_q <= wpsum_q - (full_before ? wp_rd : 64'd0) + wp_q;
					zbits_q[wptr_q] <= zero_q;
					wptr_q  <= wptr_nx;
					if (!full_before) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= full_after ? F_FRQ : F_IDLE;
				end
				F_FRQ: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (q_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			k_q    <= k_eff;
			neg_q  <= p_sat < 0;
			mag_q  <= (p_sat < 0) ? 32'(-p_sat) : 32'(p_sat);
			s_q    <= s_sat;
			freq_q <= freq_code;
			zero_q <= sigma_in == 32'd0;
		end
		if (state_q == F_SQ && sq_tiny) begin
			w_q <= ivwm_pkg::WEIGHT_MAX;
		end
		if (state_q == F_DIV && div_done) begin
			w_q <= div_ovf ? ivwm_pkg::WEIGHT_MAX : div_quot;
		end
		if (state_q == F_MUL1) begin
			hi_q <= 58'(w_q[47:ivwm_pkg::WP_SHIFT]) * 58'(mag_q);
		end
		if (state_q == F_MUL2) begin
			wp_q <= neg_q ? (~wp_mag + 64'd1) : wp_mag;
		end
		if (state_q == F_UPD) begin
			old_out_q <= old_out;
		end
		if (state_q == F_FRQ) begin
			zeros_q <= zeros_any;
		end
	end

	// a register write in idle takes priority, the bin waits
	assign in_ready = (state_q == F_IDLE) && !cfg_we;
	assign q_valid  = state_q == F_PUSH;

	assign q_data.weight_sum = wsum_q;
	assign q_data.wpower_sum = wpsum_q;
	assign q_data.freq       = freq_rd;
	assign q_data.sigma_zero = zeros_q;

endmodule

// ----- hw/rtl/ivwm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivwm_queue
// short fifo of window sums between front and back end
// ----------------------------------------------------------------------------
module ivwm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  ivwm_pkg::win_sum_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output ivwm_pkg::win_sum_t pop_data
);

	localparam int unsigned DEPTH = ivwm_pkg::QUEUE_DEPTH;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	ivwm_pkg::win_sum_t entry_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	assign pop_data = entry_q[rd_q];

endmodule

// ----- hw/rtl/ivwm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivwm_back
// mean power, merged sigma and limit from one window's sums
// ----------------------------------------------------------------------------
module ivwm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  ivwm_pkg::win_sum_t q_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] merged_power,
	output logic [31:0]        merged_sigma,
	output logic [31:0]        limit_value,
	output logic [31:0]        window_freq,
	output logic               sigma_zero
);

	localparam int unsigned NW = ivwm_pkg::BACK_NUM_W;

	typedef enum logic [6:0] {
		B_IDLE = 7'b000_0001,
		B_DIV1 = 7'b000_0010,
		B_DIV2 = 7'b000_0100,
		B_SQ1  = 7'b000_1000,
		B_LIM  = 7'b001_0000,
		B_SQ2  = 7'b010_0000,
		B_OUT  = 7'b100_0000
	} back_state_t;

	back_state_t state_q;

	logic [63:0] d_q;
	logic        neg_q;
	logic [31:0] freq_q;
	logic        zeros_q;
	logic [31:0] power_q;
	logic [31:0] sig_q;
	logic [31:0] lim_q;

	logic        out_valid_q;
	logic [31:0] out_power_q;
	logic [31:0] out_sigma_q;
	logic [31:0] out_limit_q;
	logic [31:0] out_freq_q;
	logic        out_zero_q;

	// magnitude of the popped weighted power sum
	logic        in_neg;
	logic [63:0] in_mag;

	assign in_neg = q_data.wpower_sum[63];
	assign in_mag = in_neg ? (~q_data.wpower_sum + 64'd1) : q_data.wpower_sum;

	// shared divider: mean power first, then the weight-sum reciprocal
	logic          div_start;
	logic [NW-1:0] div_num;
	logic          div_done;
	logic [63:0]   div_quot;
	logic          div_ovf;
	logic          d_small;

	assign d_small   = d_q <= 64'd1;
	assign div_start = (state_q == B_IDLE && q_valid)
		|| (state_q == B_DIV1 && div_done && !d_small);
	assign div_num   = (state_q == B_IDLE) ? {in_mag, {ivwm_pkg::WP_SHIFT{1'b0}}}
		: (NW'(1) << 64);

	ivwm_divu #(
		.NUM_W(NW),
		.QUO_W(64)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   ((state_q == B_IDLE) ? q_data.weight_sum : d_q),
		.done  (div_done),
		.quot  (div_quot),
		.ovf   (div_ovf)
	);

	// mean power with saturation
	logic [31:0] q_cap;
	logic [31:0] mean;

	always_comb begin
		if (d_q == 64'd0) begin
			q_cap = '0;
		end else if (div_ovf || (div_quot[63:32] != 32'd0)) begin
			q_cap = 32'hFFFF_FFFF;
		end else begin
			q_cap = div_quot[31:0];
		end
		if (neg_q) begin
			mean = ~((q_cap > 32'h8000_0000) ? 32'h8000_0000 : q_cap) + 32'd1;
		end else begin
			mean = (q_cap > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_cap;
		end
	end

	// shared square root: merged sigma (skipped when the weight sum is 0 or 1), then the limit
	logic        sq_start;
	logic [63:0] sq_x;
	logic        sq_done;
	logic [31:0] sq_root;
	logic [34:0] sig5;

	assign sig5     = 35'(sig_q) * 35'd5;
	assign sq_start = (state_q == B_DIV2 && div_done) || (state_q == B_LIM);
	assign sq_x     = (state_q == B_LIM) ? 64'({sig5, 16'd0}) : div_quot;

	ivwm_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.x     (sq_x),
		.done  (sq_done),
		.root  (sq_root)
	);

	logic out_load;

	assign out_load = (state_q == B_OUT) && (!out_valid_q || out_ready);
	assign q_ready  = state_q == B_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_DIV1;
					end
				end
				B_DIV1: begin
					if (div_done) begin
						state_q <= d_small ? B_LIM : B_DIV2;
					end
				end
				B_DIV2: begin
					if (div_done) begin
						state_q <= B_SQ1;
					end
				end
				B_SQ1: begin
					if (sq_done) begin
						state_q <= B_LIM;
					end
				end
				B_LIM: begin
					state_q <= B_SQ2;
				end
				B_SQ2: begin
					if (sq_done) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_valid) begin
			d_q     <= q_data.weight_sum;
			neg_q   <= in_neg;
			freq_q  <= q_data.freq;
			zeros_q <= q_data.sigma_zero;
		end
		if (state_q == B_DIV1 && div_done) begin
			power_q <= mean;
			if (d_small) begin
				sig_q <= (d_q == 64'd0) ? 32'd0 : 32'hFFFF_FFFF;
			end
		end
		if (state_q == B_SQ1 && sq_done) begin
			sig_q <= sq_root;
		end
		if (state_q == B_SQ2 && sq_done) begin
			lim_q <= sq_root;
		end
		if (out_load) begin
			out_power_q <= power_q;
			out_sigma_q <= sig_q;
			out_limit_q <= lim_q;
			out_freq_q  <= freq_q;
			out_zero_q  <= zeros_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign merged_power = out_power_q;
	assign merged_sigma = out_sigma_q;
	assign limit_value  = out_limit_q;
	assign window_freq  = out_freq_q;
	assign sigma_zero   = out_zero_q;

endmodule

// ----- hw/rtl/inverse_variance_window_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_variance_window_merge
// inverse-variance weighted moving average over spectrum bins
// ----------------------------------------------------------------------------
// Each accepted bin is scaled by the window length K, weighted by 1/sigma^2 and
// pushed into a ring of MAX_WINDOW entries; once K bins are held every new bin
// gives one result: weighted mean power, merged sigma 1/sqrt(sum w), limit
// sqrt(5*sigma) and the frequency tag of the oldest bin. The front end takes
// one bin at a time through its 65-step reciprocal divider (a tiny or zero
// sigma skips the divider). The back end works one result at a time through
// two 86-step divisions on one shared divider and two 32-step square roots
// (the second division and the first root are skipped when the weight sum is
// 0 or 1). A two-entry queue lets the front end work on the next bin while
// the back end finishes. Writing window_len (only while idle) also clears
// the window, as restart does.
// ----------------------------------------------------------------------------
module inverse_variance_window_merge #(
	parameter int unsigned MAX_WINDOW = ivwm_pkg::MAX_WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// window length register
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	// bin input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] power_in,
	input  logic [31:0]        sigma_in,
	input  logic [31:0]        freq_code,
	input  logic               restart,
	// merged result
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] merged_power,
	output logic [31:0]        merged_sigma,
	output logic [31:0]        limit_value,
	output logic [31:0]        window_freq,
	output logic               sigma_zero
);

	// front end to queue
	logic               fq_valid;
	logic               fq_ready;
	ivwm_pkg::win_sum_t fq_data;

	// queue to back end
	logic               bq_valid;
	logic               bq_ready;
	ivwm_pkg::win_sum_t bq_data;

	// scaling, weight, weighted power and the window ring
	ivwm_front #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.power_in (power_in),
		.sigma_in (sigma_in),
		.freq_code(freq_code),
		.restart  (restart),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data)
	);

	// decouples the two ends
	ivwm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_data),
		.pop_valid (bq_valid),
		.pop_ready (bq_ready),
		.pop_data  (bq_data)
	);

	// division and square roots, output register
	ivwm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (bq_valid),
		.q_ready     (bq_ready),
		.q_data      (bq_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.merged_power(merged_power),
		.merged_sigma(merged_sigma),
		.limit_value (limit_value),
		.window_freq (window_freq),
		.sigma_zero  (sigma_zero)
	);

endmodule

// ----- hw/rtl/ivwm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivwm_checker
// port-level checks of the window merge block, bound to the top level
// ----------------------------------------------------------------------------
module ivwm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [4:0]         cfg_wdata,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [31:0] power_in,
	input logic [31:0]        sigma_in,
	input logic [31:0]        freq_code,
	input logic               restart,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] merged_power,
	input logic [31:0]        merged_sigma,
	input logic [31:0]        limit_value,
	input logic [31:0]        window_freq,
	input logic               sigma_zero
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(merged_power)
			&& $stable(merged_sigma) && $stable(window_freq))
	else $error("stalled result changed");

	// one bin at a time: busy right after a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input taken while busy");

	// a zero sigma saturates its weight, so the merged sigma stays small
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sigma_zero |-> merged_sigma <= 32'd256)
	else $error("merged sigma too large with zero sigma");

	// limit is the root of at most 5 * 2^48
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> limit_value < 32'h0400_0000)
	else $error("limit out of range");

endmodule

bind inverse_variance_window_merge ivwm_checker u_ivwm_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the inverse-variance window merge block
// ----------------------------------------------------------------------------
// Bins are sent over a valid/ready channel while a bit-exact predictor works
// out the merged result of every full window. Each result transaction is
// checked field by field against the oldest prediction. The run goes through
// several window lengths, including 0 and 31, which act as 1 and 16.
// Both sides idle at random, the receiver holds off long enough to stall the
// input, and the sender pauses until the block drains.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned RING      = ivwm_pkg::MAX_WINDOW_DEF;
	localparam int unsigned SETTLE    = 400;       // cycles for a bin in flight
	localparam longint      LIMIT     = 6_000_000; // cycle count that ends a hung run

	typedef struct {
		logic signed [31:0] power;
		logic [31:0]        sigma;
		logic [31:0]        limit;
		logic [31:0]        freq;
		logic               zero;
	} merged_bin_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [4:0]         cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] power_in = '0;
	logic [31:0]        sigma_in = '0;
	logic [31:0]        freq_code = '0;
	logic               restart = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] merged_power;
	logic [31:0]        merged_sigma;
	logic [31:0]        limit_value;
	logic [31:0]        window_freq;
	logic               sigma_zero;

	// predicted results waiting for their transaction
	merged_bin_t expected_bins[$];

	// predictor copy of the block state
	logic [4:0]  pred_len;
	logic [63:0] ring_weight [RING];
	logic [63:0] ring_wpower [RING];
	logic [31:0] ring_freq   [RING];
	logic        ring_zero   [RING];
	logic [63:0] sum_weight;
	logic [63:0] sum_wpower;
	int unsigned held_bins;
	int unsigned ring_ptr;

	int     snd_idle_pct = 0;
	int     rcv_idle_pct = 0;
	int     hold_left    = 0;
	int     mismatches   = 0;
	int     bins_sent    = 0;
	int     bins_checked = 0;
	longint cycle_count  = 0;

	inverse_variance_window_merge u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.power_in     (power_in),
		.sigma_in     (sigma_in),
		.freq_code    (freq_code),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.merged_power (merged_power),
		.merged_sigma (merged_sigma),
		.limit_value  (limit_value),
		.window_freq  (window_freq),
		.sigma_zero   (sigma_zero)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// watchdog
	initial begin
		wait (cycle_count >= LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			expected_bins.size());
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic void clear_ring();
		for (int i = 0; i < RING; i++) begin
			ring_weight[i] = '0;
			ring_wpower[i] = '0;
			ring_freq[i]   = '0;
			ring_zero[i]   = 1'b0;
		end
		sum_weight = '0;
		sum_wpower = '0;
		held_bins  = 0;
		ring_ptr   = 0;
	endfunction

	function automatic int unsigned window_k();
		if (pred_len == 0) return 1;
		if (pred_len > RING) return RING;
		return pred_len;
	endfunction

	// floor(2^64 / d), d >= 2
	function automatic logic [63:0] recip_2p64(input logic [63:0] d);
		logic [64:0] num;
		logic [64:0] quo;
		num = {1'b1, 64'd0};
		quo = num / {1'b0, d};
		return quo[63:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = '0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// advance the predictor by one bin, returns 1 when a window is full
	function automatic bit merge_bin(input logic signed [31:0] pw, input logic [31:0] sg,
		input logic [31:0] fq, input logic rs, output merged_bin_t res);
		int unsigned k;
		int unsigned old;
		longint      p;
		logic [63:0] s;
		logic [63:0] w;
		logic [63:0] mag;
		logic [63:0] wp;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] d;
		logic [63:0] sig;
		logic [63:0] lim;
		bit          neg;
		bit          zeros;
		k = window_k();
		if (rs) clear_ring();

		// scale by the window length with saturation
		p = longint'(pw) * longint'(k);
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		s = {32'd0, sg} * 64'(k);
		if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;

		if (s * s <= ivwm_pkg::TINY_SQ) w = {16'd0, ivwm_pkg::WEIGHT_MAX};
		else w = recip_2p64(s * s);

		neg = p < 0;
		mag = neg ? 64'(-p) : 64'(p);
		wp = (w >> ivwm_pkg::WP_SHIFT) * mag
			+ (((w & ((64'd1 << ivwm_pkg::WP_SHIFT) - 1)) * mag) >> ivwm_pkg::WP_SHIFT);
		if (neg) wp = ~wp + 1;

		if (held_bins >= k) begin
			old = (ring_ptr + RING - k) % RING;
			sum_weight -= ring_weight[old];
			sum_wpower -= ring_wpower[old];
		end
		ring_weight[ring_ptr] = w;
		ring_wpower[ring_ptr] = wp;
		ring_freq[ring_ptr]   = fq;
		ring_zero[ring_ptr]   = (sg == 0);
		sum_weight += w;
		sum_wpower += wp;
		ring_ptr = (ring_ptr + 1) % RING;
		if (held_bins < k) held_bins++;
		if (held_bins < k) return 0;

		old = (ring_ptr + RING - k) % RING;
		zeros = 0;
		for (int i = 0; i < k; i++)
			if (ring_zero[(old + i) % RING]) zeros = 1;

		// mean power: long division with 22 fraction bits
		d = sum_weight;
		neg = sum_wpower[63];
		mag = neg ? ~sum_wpower + 1 : sum_wpower;
		if (d == 0) begin
			q = 0;
		end else begin
			q = mag / d;
			r = mag % d;
			if (q >= 1024) begin
				q = 64'hFFFF_FFFF;
			end else begin
				for (int i = 0; i < ivwm_pkg::WP_SHIFT; i++) begin
					r = r << 1;
					q = q << 1;
					if (r >= d) begin
						r = r - d;
						q = q | 1;
					end
				end
			end
		end
		if (neg) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			q = ~q + 1;
		end else if (q > 64'h7FFF_FFFF) begin
			q = 64'h7FFF_FFFF;
		end

		if (d == 0) sig = 0;
		else if (d == 1) sig = 64'hFFFF_FFFF;
		else sig = int_sqrt(recip_2p64(d));
		if (sig > 64'hFFFF_FFFF) sig = 64'hFFFF_FFFF;
		lim = int_sqrt(64'd5 * sig * 64'd65536);

		res.power = q[31:0];
		res.sigma = sig[31:0];
		res.limit = lim[31:0];
		res.freq  = ring_freq[old];
		res.zero  = zeros;
		return 1;
	endfunction

	// ------------------------------------------------------------------
	// result side: ready pattern, hold-off and checking
	// ------------------------------------------------------------------
	task automatic check_result();
		merged_bin_t e;
		bins_checked++;
		if (expected_bins.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result transaction: power %h sigma %h", merged_power,
					merged_sigma);
			return;
		end
		e = expected_bins.pop_front();
		if (merged_power !== e.power || merged_sigma !== e.sigma ||
			limit_value !== e.limit || window_freq !== e.freq || sigma_zero !== e.zero) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch on result %0d", bins_checked);
				$display("  expected power %h sigma %h limit %h freq %h zero %b",
					e.power, e.sigma, e.limit, e.freq, e.zero);
				$display("  actual   power %h sigma %h limit %h freq %h zero %b",
					merged_power, merged_sigma, limit_value, window_freq, sigma_zero);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// sampled before this edge updates anything
			if (out_valid && out_ready) check_result();
			if (hold_left > 0) begin
				// long hold-off so the block backs up into its input
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// bin side
	// ------------------------------------------------------------------
	task automatic send_bin(input logic signed [31:0] pw, input logic [31:0] sg,
		input logic [31:0] fq, input logic rs);
		merged_bin_t res;
		if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		power_in  <= pw;
		sigma_in  <= sg;
		freq_code <= fq;
		restart   <= rs;
		do @(posedge clk); while (!in_ready);
		bins_sent++;
		if (merge_bin(pw, sg, fq, rs, res)) expected_bins = {expected_bins, res};
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	// every prediction answered
	task automatic wait_results();
		while (expected_bins.size() != 0) @(posedge clk);
	endtask

	// drain, then give a bin that makes no result time to finish
	task automatic wait_idle();
		stop_sending();
		wait_results();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_window_len(input logic [4:0] len);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pred_len = len;
		clear_ring();
		@(posedge clk);
	endtask

	task automatic send_random_bin();
		logic signed [31:0] pw;
		logic [31:0]        sg;
		case ($urandom_range(9))
			0: pw = 32'sh7FFF_FFFF;
			1: pw = 32'sh8000_0000;
			2: pw = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			default: pw = $urandom;
		endcase
		case ($urandom_range(19))
			0: sg = 0;
			1, 2: sg = $urandom_range(1, 300);
			3, 4: sg = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
			5, 6, 7, 8, 9: sg = $urandom_range(32'h0000_1000, 32'h0010_0000);
			default: sg = $urandom;
		endcase
		send_bin(pw, sg, $urandom, ($urandom_range(49) == 0));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// default window of five: field extremes, zero and tiny sigma, restart
	task automatic test_default_window();
		send_bin(32'sh7FFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
		send_bin(32'sh8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		send_bin(32'sh0000_0000, 32'h0000_0001, 32'h1234_5678, 1'b0);
		send_bin(32'sh0001_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0);
		send_bin(-32'sh0002_8000, 32'h0000_3000, 32'h5A5A_5A5A, 1'b0);
		send_bin(32'sh0000_4000, 32'h0000_2000, 32'h0000_0006, 1'b0);
		send_bin(32'sh0000_4000, 32'h0000_2000, 32'h0000_0007, 1'b1);
		// four at the largest sigma: each adds a weight of one
		repeat (4) send_bin(32'sh0003_0000, 32'hFFFF_FFFF, 32'h0000_0008, 1'b0);
	endtask

	// length 0 acts as 1: weight sum of one saturates the merged sigma
	task automatic test_window_of_one();
		write_window_len(5'd0);
		send_bin(32'sh0001_0000, 32'hFFFF_FFFF, 32'h0000_0101, 1'b0);
		send_bin(32'sh8000_0000, 32'h0000_0000, 32'h0000_0102, 1'b0);
		send_bin(32'sh7FFF_FFFF, 32'h0000_0100, 32'h0000_0103, 1'b1);
	endtask

	// random phases across window lengths and idle patterns
	task automatic test_random_windows();
		logic [4:0] lens[9] = '{5'd31, 5'd1, 5'd16, 5'd2, 5'd3, 5'd0, 5'd7, 5'd5, 5'd12};
		for (int ph = 0; ph < 9; ph++) begin
			write_window_len(lens[ph]);
			if (ph < 3) begin
				snd_idle_pct = 34;
				rcv_idle_pct = 53;
			end else if (ph < 6) begin
				snd_idle_pct = 53;
				rcv_idle_pct = 34;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			repeat (145) send_random_bin();
		end
	endtask

	// receiver holds off while bins keep coming, so the input stalls
	task automatic test_output_hold_off();
		write_window_len(5'd1);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_left = 3000;
		repeat (20) send_random_bin();
	endtask

	// sender stops until everything has come out, then resumes
	task automatic test_sender_pause();
		write_window_len(5'd4);
		repeat (12) send_random_bin();
		stop_sending();
		wait_results();
		repeat (12) send_random_bin();
	endtask

	initial begin
		pred_len = ivwm_pkg::WINDOW_LEN_RST;
		clear_ring();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_window_of_one();
		test_random_windows();
		test_output_hold_off();
		test_sender_pause();

		stop_sending();
		wait_results();
		repeat (SETTLE) @(posedge clk);

		$display("%0d bins sent, %0d results checked over window lengths 0..31", bins_sent,
			bins_checked);
		$display("idle patterns, a long output hold-off and a drain pause, %0d mismatches",
			mismatches);
		if (mismatches == 0 && expected_bins.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/ivwm_pkg.sv
hw/rtl/ivwm_ram.sv
hw/rtl/ivwm_divu.sv
hw/rtl/ivwm_sqrt.sv
hw/rtl/ivwm_front.sv
hw/rtl/ivwm_queue.sv
hw/rtl/ivwm_back.sv
hw/rtl/inverse_variance_window_merge.sv
hw/rtl/ivwm_checker.sv
verif/testbench.sv
